// ===== rtl/core/tfds_pkg.sv =====
package tfds_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 3;
    localparam int COEF_W     = 17;
    localparam int DRIVE_W    = 16;
    localparam int STATE_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_MIX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 2'd3;

    localparam logic [COEF_W-1:0]  ONE_Q16           = 17'd65536;
    localparam logic [COEF_W-1:0]  LOWPASS_COEFF_RST = 17'd3932;
    localparam logic [COEF_W-1:0]  TONE_MIX_RST      = 17'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_GAIN_RST    = 16'd16384;
    localparam logic [COEF_W-1:0]  WET_MIX_RST       = 17'd0;

    localparam int MAX_CHANNELS_DEF = 8;

    // tanh curve, tanh(8*i/TANH_N) in q0.16
    localparam int TANH_N = 256;
    localparam int TANH_W = 17;
    localparam int FRAC_W = 26;

    localparam logic [63:0] TWO32 = 64'h1_0000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CH_W-1:0]            channel_index;
        logic                       block_last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_last_out;
    } t_out_item;

    typedef logic [TANH_W-1:0] t_tanh_point;
    typedef t_tanh_point [TANH_N:0] t_tanh_tab;

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tanh_tab build_tanh_tab();
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        t_tanh_tab   tab;
        term = TWO32;
        r    = TWO32;
        e    = TWO32;
        // series for exp(-16/n)
        for (int k = 1; k < 40; k++) begin
            term = udiv64(term * 64'd16, 64'(TANH_N * k));
            if (k[0]) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int i = 0; i <= TANH_N; i++) begin
            if (i > 0) begin
                e = (e * r + 64'h8000_0000) >> 32;
            end
            den    = TWO32 + e;
            num    = ((TWO32 - e) << 16) + (den >> 1);
            tab[i] = TANH_W'(udiv64(num, den));
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh_tab();

endpackage

// ===== rtl/core/tfds_ram.sv =====
module tfds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tone_filter_drive_saturator_core.sv =====
// tone filter with drive saturation, one audio sample per transaction
//
// input channel: i_in_valid / o_in_ready, payload i_in_data (sample, channel, block end)
// output channel: o_out_valid / i_out_ready, payload o_out_data (sample, block end copy)
// config port: i_cfg_we writes i_cfg_data to register i_cfg_idx in the same cycle
//   (0 lowpass coeff, 1 tone mix, 2 drive gain, 3 wet mix); write only while idle (not enforced)
//
// one transaction is processed at a time, and the next is not taken until its result
// is loaded into the output register. the pace is set by the single shared 27x18
// multiplier, which runs six dependent products per sample, and by the registered read
// of the per-channel lowpass state ram. the next transaction is accepted while a result
// still waits in the output register; a stalled receiver holds the block in its last
// step until the output register frees up, after which input is accepted again.
//
// reset clears all lowpass states (per-channel valid flags, no clearing pass), loads the
// register defaults and empties the output register.
module tone_filter_drive_saturator_core
    import tfds_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_N   = 2 ** CH_W;
    localparam int MA_W   = 27;
    localparam int MB_W   = 18;
    localparam int P_W    = MA_W + MB_W;
    localparam int COL_W  = 26;
    localparam int DRV_W  = 29;
    localparam int MAG_W  = 28;
    localparam int DRY_W  = 34;
    localparam int ACC_W  = 36;
    localparam int TIDX_W = $clog2(TANH_N + 1);
    localparam int POS_W  = MAG_W + TIDX_W;
    localparam int IDXR_W = POS_W - FRAC_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_LP   = 4'd1;
    localparam logic [3:0] ST_UPDATE   = 4'd2;
    localparam logic [3:0] ST_MUL_TONE = 4'd3;
    localparam logic [3:0] ST_COLOUR   = 4'd4;
    localparam logic [3:0] ST_MUL_DRV  = 4'd5;
    localparam logic [3:0] ST_DRIVE    = 4'd6;
    localparam logic [3:0] ST_LOOKUP   = 4'd7;
    localparam logic [3:0] ST_MUL_INTP = 4'd8;
    localparam logic [3:0] ST_SHAPE    = 4'd9;
    localparam logic [3:0] ST_MUL_WET  = 4'd10;
    localparam logic [3:0] ST_FINISH   = 4'd11;

    function automatic logic signed [P_W-1:0] rnd_shr(input logic signed [P_W-1:0] v,
                                                      input int s);
        return (v + (P_W'(1) << (s - 1))) >>> s;
    endfunction

    logic [3:0]                 r_state;
    logic [COEF_W-1:0]          r_lp_coeff;
    logic [COEF_W-1:0]          r_tone_mix;
    logic [DRIVE_W-1:0]         r_drive;
    logic [COEF_W-1:0]          r_wet_mix;
    logic [MAX_CHANNELS-1:0]    r_valid;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic signed [SAMPLE_W-1:0] r_x;
    logic [ADDR_W-1:0]          r_slot;
    logic                       r_last;
    logic signed [STATE_W-1:0]  r_lp;
    logic signed [COL_W-1:0]    r_col;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic [TANH_W-1:0]          r_t0;
    logic signed [MB_W-1:0]     r_d;
    logic [FRAC_W-1:0]          r_frac;
    logic signed [MB_W-1:0]     r_shaped;
    logic signed [DRY_W-1:0]    r_dry;
    logic signed [P_W-1:0]      r_prod;

    logic [ADDR_W-1:0]          slot_of [CH_N];
    logic [ADDR_W-1:0]          in_slot;
    logic                       in_accept;
    logic                       out_load;
    logic [STATE_W-1:0]         ram_rdata;
    logic                       ram_we;

    logic [COEF_W-1:0]          lp_coeff_q;
    logic [COEF_W-1:0]          tone_q;
    logic [COEF_W-1:0]          wet_q;
    logic [COEF_W-1:0]          dry_q;

    logic signed [STATE_W-1:0]  x_big;
    logic signed [STATE_W-1:0]  lp_rd;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic                       mul_en;

    logic signed [STATE_W-1:0]  n_lp;
    logic signed [COL_W-1:0]    n_col;
    logic signed [DRV_W-1:0]    n_drv;
    logic [MAG_W-1:0]           n_mag;
    logic [POS_W-1:0]           pos;
    logic [IDXR_W-1:0]          idx_raw;
    logic [TIDX_W-1:0]          idx_lo;
    logic [TIDX_W-1:0]          idx_hi;
    logic [TANH_W-1:0]          t_lo;
    logic [TANH_W-1:0]          t_hi;
    logic signed [MB_W-1:0]     n_d;
    logic signed [MB_W-1:0]     y;
    logic signed [MB_W-1:0]     n_shaped;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ACC_W-1:0]    acc;
    logic signed [SAMPLE_W-1:0] n_sample;

    // channel to state slot, wraps past the state depth
    for (genvar g = 0; g < CH_N; g++) begin : g_slot
        localparam int SLOT = g % MAX_CHANNELS;
        assign slot_of[g] = ADDR_W'(SLOT);
    end

    assign in_slot    = slot_of[i_in_data.channel_index];
    assign o_in_ready = i_rst_n && (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign ram_we     = (r_state == ST_UPDATE);

    tfds_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (n_lp),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    // fractions above one act as one
    assign lp_coeff_q = (r_lp_coeff > ONE_Q16) ? ONE_Q16 : r_lp_coeff;
    assign tone_q     = (r_tone_mix > ONE_Q16) ? ONE_Q16 : r_tone_mix;
    assign wet_q      = (r_wet_mix > ONE_Q16) ? ONE_Q16 : r_wet_mix;
    assign dry_q      = ONE_Q16 - wet_q;

    assign x_big = {r_x, 8'd0};
    assign lp_rd = r_valid[r_slot] ? signed'(ram_rdata) : '0;

    // shared multiplier operands
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (r_state)
            ST_MUL_LP: begin
                mul_a  = MA_W'(x_big) - MA_W'(lp_rd);
                mul_b  = {1'b0, lp_coeff_q};
                mul_en = 1'b1;
            end
            ST_UPDATE: begin
                mul_a  = MA_W'(r_x);
                mul_b  = {1'b0, dry_q};
                mul_en = 1'b1;
            end
            ST_MUL_TONE: begin
                mul_a  = MA_W'(x_big) - (MA_W'(r_lp) <<< 1);
                mul_b  = {1'b0, tone_q};
                mul_en = 1'b1;
            end
            ST_MUL_DRV: begin
                mul_a  = MA_W'(r_col);
                mul_b  = {2'b00, r_drive};
                mul_en = 1'b1;
            end
            ST_MUL_INTP: begin
                mul_a  = {1'b0, r_frac};
                mul_b  = r_d;
                mul_en = 1'b1;
            end
            ST_MUL_WET: begin
                mul_a  = MA_W'(r_shaped);
                mul_b  = {1'b0, wet_q};
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_lp  = r_lp + STATE_W'(rnd_shr(r_prod, 16));
        n_col = COL_W'(r_lp) + COL_W'(rnd_shr(r_prod, 16));
        n_drv = DRV_W'(rnd_shr(r_prod, 14));
        n_mag = n_drv[DRV_W-1] ? MAG_W'(-n_drv) : MAG_W'(n_drv);

        // table position, past the end sticks at the last point
        pos     = POS_W'(r_mag) * POS_W'(TANH_N);
        idx_raw = pos[POS_W-1:FRAC_W];
        idx_lo  = (idx_raw >= IDXR_W'(TANH_N)) ? TIDX_W'(TANH_N) : idx_raw[TIDX_W-1:0];
        idx_hi  = (idx_raw >= IDXR_W'(TANH_N - 1)) ? TIDX_W'(TANH_N) : idx_lo + 1'b1;
        t_lo    = TANH_TAB[idx_lo];
        t_hi    = TANH_TAB[idx_hi];
        n_d     = signed'({1'b0, t_hi}) - signed'({1'b0, t_lo});

        y        = signed'({1'b0, r_t0}) + MB_W'(rnd_shr(r_prod, FRAC_W));
        n_shaped = r_neg ? -y : y;

        sum = (ACC_W'(r_dry) <<< 1) + ACC_W'(r_prod);
        acc = (sum + (ACC_W'(1) << 16)) >>> 17;
        if (acc > ACC_W'(32767)) begin
            n_sample = 16'sd32767;
        end else if (acc < -ACC_W'(32768)) begin
            n_sample = -16'sd32768;
        end else begin
            n_sample = SAMPLE_W'(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_lp_coeff  <= LOWPASS_COEFF_RST;
            r_tone_mix  <= TONE_MIX_RST;
            r_drive     <= DRIVE_GAIN_RST;
            r_wet_mix   <= WET_MIX_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOWPASS_COEFF: r_lp_coeff <= i_cfg_data;
                    CFG_TONE_MIX:      r_tone_mix <= i_cfg_data;
                    CFG_DRIVE_GAIN:    r_drive    <= i_cfg_data[DRIVE_W-1:0];
                    CFG_WET_MIX:       r_wet_mix  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (ram_we) begin
                r_valid[r_slot] <= 1'b1;
            end

            case (r_state)
                ST_IDLE:     if (in_accept) r_state <= ST_MUL_LP;
                ST_MUL_LP:   r_state <= ST_UPDATE;
                ST_UPDATE:   r_state <= ST_MUL_TONE;
                ST_MUL_TONE: r_state <= ST_COLOUR;
                ST_COLOUR:   r_state <= ST_MUL_DRV;
                ST_MUL_DRV:  r_state <= ST_DRIVE;
                ST_DRIVE:    r_state <= ST_LOOKUP;
                ST_LOOKUP:   r_state <= ST_MUL_INTP;
                ST_MUL_INTP: r_state <= ST_SHAPE;
                ST_SHAPE:    r_state <= ST_MUL_WET;
                ST_MUL_WET:  r_state <= ST_FINISH;
                ST_FINISH:   if (out_load) r_state <= ST_IDLE;
                default:     r_state <= ST_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x    <= i_in_data.sample_in;
            r_slot <= in_slot;
            r_last <= i_in_data.block_last;
        end
        if (mul_en) begin
            r_prod <= P_W'(mul_a) * P_W'(mul_b);
        end
        case (r_state)
            ST_MUL_LP: begin
                r_lp <= lp_rd;
            end
            ST_UPDATE: begin
                r_lp <= n_lp;
            end
            ST_MUL_TONE: begin
                r_dry <= DRY_W'(r_prod);
            end
            ST_COLOUR: begin
                r_col <= n_col;
            end
            ST_DRIVE: begin
                r_neg <= n_drv[DRV_W-1];
                r_mag <= n_mag;
            end
            ST_LOOKUP: begin
                r_t0   <= t_lo;
                r_d    <= n_d;
                r_frac <= pos[FRAC_W-1:0];
            end
            ST_SHAPE: begin
                r_shaped <= n_shaped;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data.sample_out     <= n_sample;
            r_out_data.block_last_out <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/tfds_checker.sv =====
module tfds_checker
    import tfds_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    localparam int RESULT_LAT = 12;

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while busy");

    // a fresh result appears a fixed time after its transaction
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, RESULT_LAT))
        else $error("result without matching transaction");

    // returning to idle after work means a result was handed over
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_in_ready) && $past(i_rst_n)) |-> o_out_valid)
        else $error("back to idle without a result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind tone_filter_drive_saturator_core tfds_checker u_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top
    import tfds_pkg::*;
();

    localparam int NUM_CHANNELS   = 8;
    localparam int TANH_POINTS    = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int PHASE_ITEMS    = 80;
    localparam longint FRAC_MASK  = 64'h3FF_FFFF;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    t_in_item  pending_samples[$];
    t_out_item expected_outputs[$];
    t_out_item oldest_expected;

    longint lowpass_mem [NUM_CHANNELS];
    longint tanh_points [TANH_POINTS+1];

    logic [16:0] coeff_reg = 17'd3932;
    logic [16:0] tone_reg  = 17'd0;
    logic [15:0] drive_reg = 16'd16384;
    logic [16:0] wet_reg   = 17'd0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_input = 1'b0;
    int  fail_count = 0;
    int  stuck_cycles = 0;

    tone_filter_drive_saturator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint frac_reg(logic [16:0] v);
        return (v > 17'd65536) ? 64'd65536 : longint'(v);
    endfunction

    // tanh(8*i/n) in q0.16 via exp(-16/n) series
    function automatic void make_tanh_points();
        logic [127:0] term;
        logic [127:0] ratio;
        logic [127:0] e;
        logic [127:0] den;
        logic [127:0] q;
        term  = 128'h1_0000_0000;
        ratio = 128'h1_0000_0000;
        e     = 128'h1_0000_0000;
        for (int k = 1; k < 40; k++) begin
            term = (term * 16) / (TANH_POINTS * k);
            if (k % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        for (int i = 0; i <= TANH_POINTS; i++) begin
            if (i > 0) begin
                e = (e * ratio + 128'h8000_0000) >> 32;
            end
            den = 128'h1_0000_0000 + e;
            q   = (((128'h1_0000_0000 - e) << 16) + (den >> 1)) / den;
            tanh_points[i] = longint'(q[31:0]);
        end
    endfunction

    function automatic t_out_item tone_drive_sample(t_in_item item);
        longint x, bigx, lp, hp, colored, driven, mag, pos, y, shaped, acc;
        longint c, m, wet, dry, drive, idx, frac, d;
        int ch;
        t_out_item res;
        x     = item.sample_in;
        ch    = int'(item.channel_index) % NUM_CHANNELS;
        c     = frac_reg(coeff_reg);
        m     = frac_reg(tone_reg);
        wet   = frac_reg(wet_reg);
        dry   = 65536 - wet;
        drive = longint'(drive_reg);
        bigx  = x * 256;
        lp    = lowpass_mem[ch];
        lp    = lp + round_shift((bigx - lp) * c, 16);
        lowpass_mem[ch] = lp;
        hp      = bigx - lp;
        colored = round_shift((65536 - m) * lp + m * hp, 16);
        driven  = round_shift(colored * drive, 14);
        mag     = (driven < 0) ? -driven : driven;
        pos     = mag * TANH_POINTS;
        idx     = pos >>> 26;
        frac    = pos & FRAC_MASK;
        if (idx >= TANH_POINTS) begin
            y = tanh_points[TANH_POINTS];
        end else begin
            d = tanh_points[idx+1] - tanh_points[idx];
            y = tanh_points[idx] + round_shift(d * frac, 26);
        end
        shaped = (driven < 0) ? -y : y;
        acc    = round_shift(2 * dry * x + wet * shaped, 17);
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        res.sample_out     = 16'(acc);
        res.block_last_out = item.block_last;
        return res;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_outputs.push_back(tone_drive_sample(in_data));
            end
            if (!in_valid || in_ready) begin
                if (pending_samples.size() != 0 && !hold_input &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_samples.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_outputs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected output transaction: sample %0d last %0b",
                                 out_data.sample_out, out_data.block_last_out);
                    end
                end else begin
                    oldest_expected = expected_outputs.pop_front();
                    if (out_data.sample_out !== oldest_expected.sample_out ||
                        out_data.block_last_out !== oldest_expected.block_last_out) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %0d last %0b, got %0d last %0b",
                                     oldest_expected.sample_out,
                                     oldest_expected.block_last_out,
                                     out_data.sample_out, out_data.block_last_out);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (pending_samples.size() == 0 && !in_valid && expected_outputs.size() == 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic void push_item(logic signed [15:0] s, logic [2:0] ch, logic last);
        t_in_item item;
        item.sample_in     = s;
        item.channel_index = ch;
        item.block_last    = last;
        pending_samples.push_back(item);
    endfunction

    task automatic apply_settings(logic [16:0] c, logic [16:0] m, logic [16:0] d,
                                  logic [16:0] w);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_idx <= CFG_LOWPASS_COEFF; cfg_data <= c;
        coeff_reg = c;
        @(posedge clk);
        cfg_idx <= CFG_TONE_MIX; cfg_data <= m;
        tone_reg = m;
        @(posedge clk);
        cfg_idx <= CFG_DRIVE_GAIN; cfg_data <= d;
        drive_reg = d[15:0];
        @(posedge clk);
        cfg_idx <= CFG_WET_MIX; cfg_data <= w;
        wet_reg = w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        @(negedge clk);
        send_idle_pct  = (mode == IDLE_SEND) ? 85 : (mode == IDLE_BOTH) ? 6 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 85 : (mode == IDLE_BOTH) ? 6 : 0;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [16:0] pick_frac();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;
            3:       return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [16:0] pick_drive();
        case ($urandom_range(0, 5))
            0:       return 17'd16384;
            1:       return 17'd52429;
            2:       return 17'h0FFFF;
            3:       return 17'd0;
            4:       return 17'($urandom);
            default: return 17'($urandom_range(16384, 52429));
        endcase
    endfunction

    // mostly whole blocks over a few channels, some broken ones with random routing
    task automatic queue_random_blocks(int n_items);
        int made, len, nch;
        bit broken;
        logic signed [15:0] s;
        made = 0;
        while (made < n_items) begin
            len    = $urandom_range(1, 12);
            nch    = $urandom_range(1, NUM_CHANNELS);
            broken = ($urandom_range(0, 7) == 0);
            for (int j = 0; j < len && made < n_items; j++) begin
                case ($urandom_range(0, 9))
                    0:       s = 16'sh8000;
                    1:       s = 16'sh7FFF;
                    2:       s = 16'($urandom_range(0, 511) - 256);
                    default: s = 16'($urandom);
                endcase
                if (broken) begin
                    push_item(s, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                end else begin
                    push_item(s, 3'(j % nch), j == len - 1);
                end
                made++;
            end
        end
    endtask

    initial begin
        make_tanh_points();
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            lowpass_mem[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fractions above one, drive all channel states to negative full scale
        apply_settings(17'h1FFFF, 17'd0, 17'd16384, 17'h1FFFF);
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            push_item(16'sh8000, 3'(ch), ch == NUM_CHANNELS - 1);
        end
        drain();

        // frozen lowpass, full highpass, top drive: deep into the tanh table
        apply_settings(17'd0, 17'd65536, 17'h0FFFF, 17'd65536);
        push_item(16'sh7FFF, 3'd0, 1'b0);
        push_item(16'sh7FFF, 3'd1, 1'b0);
        push_item(16'sh7FFF, 3'd2, 1'b0);
        push_item(16'sh8000, 3'd3, 1'b0);
        push_item(16'sh0000, 3'd4, 1'b0);
        push_item(-16'sd1,   3'd5, 1'b0);
        push_item(16'sd1,    3'd6, 1'b0);
        push_item(16'sd16384, 3'd7, 1'b1);
        drain();

        // zero drive, tone above one, half wet
        apply_settings(17'd3932, 17'h18000, 17'h10000, 17'd32768);
        push_item(16'sh7FFF, 3'd0, 1'b1);
        push_item(16'sh8000, 3'd1, 1'b0);
        push_item(16'sd12345, 3'd2, 1'b1);
        push_item(-16'sd12345, 3'd3, 1'b0);
        push_item(16'sh7FFF, 3'd7, 1'b1);
        drain();

        // in-range drive top, mid tone, dry only
        apply_settings(17'd32768, 17'd32768, 17'd52429, 17'd0);
        push_item(16'sh7FFF, 3'd7, 1'b0);
        push_item(16'sh8000, 3'd7, 1'b0);
        push_item(16'sh5555, 3'd6, 1'b0);
        push_item(16'shAAAA, 3'd5, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                apply_settings(17'd0, 17'd0, 17'd16384, 17'd0);
            end else if (p == 1) begin
                apply_settings(17'd65536, 17'd65536, 17'd52429, 17'd65536);
            end else begin
                apply_settings(pick_frac(), pick_frac(), pick_drive(), pick_frac());
            end
            set_idling(p % 4);
            queue_random_blocks(PHASE_ITEMS);
            if (p == 5) begin
                while (pending_samples.size() > PHASE_ITEMS / 2) begin
                    @(negedge clk);
                end
                hold_input = 1'b1;
                while (in_valid || expected_outputs.size() != 0) begin
                    @(negedge clk);
                end
                hold_input = 1'b0;
            end
            drain();
        end

        if (fail_count == 0 && expected_outputs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
